/* rtl/fct_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and constants for the fluid contact table.
// ----------------------------------------------------------------------------
package fct_pkg;

    localparam int CAPACITY   = 8;
    localparam int MAX_POINTS = 64;

    localparam int KEY_W  = 32;
    localparam int PCNT_W = 7;
    localparam int PIDX_W = 6;
    localparam int SLOT_W = 3;
    localparam int CNT_W  = 4;

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_PERSIST = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_READ    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // classified command as it sits in the queue
    typedef struct packed {
        t_opcode             op;
        logic [KEY_W-1:0]    fluid_body;
        logic [KEY_W-1:0]    fluid_subshape;
        logic [KEY_W-1:0]    body_subshape;
        logic [PCNT_W-1:0]   point_count;   // already clamped to MAX_POINTS
        logic [SLOT_W-1:0]   read_slot;
    } t_cmd;

    // one table entry
    typedef struct packed {
        logic [KEY_W-1:0]    fluid_body;
        logic [KEY_W-1:0]    fluid_subshape;
        logic [KEY_W-1:0]    body_subshape;
        logic [PIDX_W-1:0]   point_index;
    } t_entry;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

/* rtl/fct_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fct_front
// Accepts input transactions, decodes the opcode and clamps the point count,
// then pushes the classified command into the queue.
// ----------------------------------------------------------------------------
module fct_front (
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_opcode,
    input  logic [fct_pkg::KEY_W-1:0]   i_fluid_body,
    input  logic [fct_pkg::KEY_W-1:0]   i_fluid_subshape,
    input  logic [fct_pkg::KEY_W-1:0]   i_body_subshape,
    input  logic [fct_pkg::PCNT_W-1:0]  i_point_count,
    input  logic [fct_pkg::SLOT_W-1:0]  i_read_slot,
    input  fct_pkg::t_qstat             i_qstat,
    output logic                        o_push,
    output fct_pkg::t_cmd               o_cmd
);
    import fct_pkg::*;

    logic [PCNT_W-1:0] clamped_count;

    // accept whenever the queue has room
    assign o_ready = !i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full;

    // counts beyond the manifold limit saturate
    always_comb begin
        if (i_point_count > PCNT_W'(MAX_POINTS)) begin
            clamped_count = PCNT_W'(MAX_POINTS);
        end else begin
            clamped_count = i_point_count;
        end
    end

    always_comb begin
        o_cmd.op             = t_opcode'(i_opcode);
        o_cmd.fluid_body     = i_fluid_body;
        o_cmd.fluid_subshape = i_fluid_subshape;
        o_cmd.body_subshape  = i_body_subshape;
        o_cmd.point_count    = clamped_count;
        o_cmd.read_slot      = i_read_slot;
    end

endmodule

/* rtl/fct_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fct_queue
// Short command FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module fct_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fct_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output fct_pkg::t_cmd  o_head,
    output fct_pkg::t_qstat o_qstat
);
    import fct_pkg::*;

    t_cmd               r_store [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count,  n_count;

    assign o_qstat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_head        = r_store[r_rd_ptr];

    // pointer and occupancy update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // payload storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* rtl/fct_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fct_back
// Holds the contact table. Each command passes through a search state (parallel
// key compare, slot selection) and a commit state (table write, result register).
// ----------------------------------------------------------------------------
module fct_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fct_pkg::t_qstat             i_qstat,
    input  fct_pkg::t_cmd               i_head,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_status,
    output logic [fct_pkg::SLOT_W-1:0]  o_slot_used,
    output logic [fct_pkg::PIDX_W-1:0]  o_point_index,
    output logic [fct_pkg::CNT_W-1:0]   o_entry_count,
    output logic [fct_pkg::KEY_W-1:0]   o_out_fluid_body,
    output logic [fct_pkg::KEY_W-1:0]   o_out_fluid_subshape,
    output logic [fct_pkg::KEY_W-1:0]   o_out_body_subshape
);
    import fct_pkg::*;

    typedef enum logic {
        S_SEARCH,
        S_COMMIT
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    t_entry              r_table [CAPACITY];

    // latched command and search result
    t_cmd                r_cmd;
    logic                r_hit;
    logic [SLOT_W-1:0]   r_slot;

    // result register
    logic                r_out_valid;
    t_status             r_status;
    logic [SLOT_W-1:0]   r_slot_used;
    logic [PIDX_W-1:0]   r_point_index;
    logic [KEY_W-1:0]    r_out_fb;
    logic [KEY_W-1:0]    r_out_fs;
    logic [KEY_W-1:0]    r_out_bs;

    logic [CAPACITY-1:0] match_vec;
    logic                match_any;
    logic [SLOT_W-1:0]   match_slot;
    logic                n_hit;
    logic [SLOT_W-1:0]   n_slot;

    logic                do_commit;
    logic [SLOT_W-1:0]   last_slot;
    t_entry              ent_slot;
    t_entry              ent_last;
    logic [PCNT_W-1:0]   next_pidx;
    logic                wr_en;
    t_entry              wr_entry;
    logic [CNT_W-1:0]    n_count;
    t_status             n_status;
    logic [SLOT_W-1:0]   n_slot_used;
    logic [PIDX_W-1:0]   n_point_index;
    logic [KEY_W-1:0]    n_out_fb;
    logic [KEY_W-1:0]    n_out_fs;
    logic [KEY_W-1:0]    n_out_bs;

    // key compare in every valid slot
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            match_vec[i] = (CNT_W'(i) < r_count)
                && (r_table[i].fluid_body     == i_head.fluid_body)
                && (r_table[i].fluid_subshape == i_head.fluid_subshape)
                && (r_table[i].body_subshape  == i_head.body_subshape);
        end
    end

    // first match wins
    always_comb begin
        match_any  = |match_vec;
        match_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                match_slot = SLOT_W'(i);
            end
        end
    end

    // classify the head command into a target slot
    always_comb begin
        case (i_head.op)
            OP_ADD: begin
                n_hit  = (r_count < CNT_W'(CAPACITY));
                n_slot = r_count[SLOT_W-1:0];
            end
            OP_PERSIST, OP_REMOVE: begin
                n_hit  = match_any;
                n_slot = match_slot;
            end
            OP_READ: begin
                n_hit  = ({1'b0, i_head.read_slot} < r_count);
                n_slot = i_head.read_slot;
            end
            default: begin
                n_hit  = 1'b0;
                n_slot = '0;
            end
        endcase
    end

    assign o_pop     = (r_state == S_SEARCH) && !i_qstat.empty;
    assign do_commit = (r_state == S_COMMIT) && (!r_out_valid || i_ready);
    assign last_slot = SLOT_W'(r_count - 1'b1);
    assign ent_slot  = r_table[r_slot];
    assign ent_last  = r_table[last_slot];
    assign next_pidx = ({1'b0, ent_slot.point_index} + 1'b1 >= r_cmd.point_count)
                       ? '0 : {1'b0, ent_slot.point_index} + 1'b1;

    // commit: table write and result values
    always_comb begin
        wr_en         = 1'b0;
        wr_entry      = ent_slot;
        n_count       = r_count;
        n_status      = ST_OK;
        n_slot_used   = '0;
        n_point_index = '0;
        n_out_fb      = '0;
        n_out_fs      = '0;
        n_out_bs      = '0;
        case (r_cmd.op)
            OP_ADD: begin
                if (r_hit) begin
                    wr_en                   = 1'b1;
                    wr_entry.fluid_body     = r_cmd.fluid_body;
                    wr_entry.fluid_subshape = r_cmd.fluid_subshape;
                    wr_entry.body_subshape  = r_cmd.body_subshape;
                    wr_entry.point_index    = '0;
                    n_count                 = r_count + 1'b1;
                    n_slot_used             = r_slot;
                end else begin
                    n_status = ST_FULL;
                end
            end
            OP_PERSIST: begin
                if (r_hit) begin
                    wr_en                = 1'b1;
                    wr_entry.point_index = next_pidx[PIDX_W-1:0];
                    n_slot_used          = r_slot;
                    n_point_index        = next_pidx[PIDX_W-1:0];
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            OP_REMOVE: begin
                if (r_hit) begin
                    // swap the last entry into the freed slot
                    wr_en         = 1'b1;
                    wr_entry      = ent_last;
                    n_count       = r_count - 1'b1;
                    n_slot_used   = r_slot;
                    n_point_index = ent_slot.point_index;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            OP_READ: begin
                if (r_hit) begin
                    n_slot_used   = r_slot;
                    n_point_index = ent_slot.point_index;
                    n_out_fb      = ent_slot.fluid_body;
                    n_out_fs      = ent_slot.fluid_subshape;
                    n_out_bs      = ent_slot.body_subshape;
                end else begin
                    n_status = ST_EMPTY;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // sequencer, count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SEARCH;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (do_commit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_SEARCH: begin
                    if (!i_qstat.empty) begin
                        r_cmd   <= i_head;
                        r_hit   <= n_hit;
                        r_slot  <= n_slot;
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (do_commit) begin
                        r_count       <= n_count;
                        r_status      <= n_status;
                        r_slot_used   <= n_slot_used;
                        r_point_index <= n_point_index;
                        r_out_fb      <= n_out_fb;
                        r_out_fs      <= n_out_fs;
                        r_out_bs      <= n_out_bs;
                        r_state       <= S_SEARCH;
                    end
                end
                default: begin
                    r_state <= S_SEARCH;
                end
            endcase
        end
    end

    // table storage, single write port
    always_ff @(posedge i_clk) begin
        if (do_commit && wr_en) begin
            r_table[r_slot] <= wr_entry;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_status             = r_status;
    assign o_slot_used          = r_slot_used;
    assign o_point_index        = r_point_index;
    assign o_entry_count        = r_count;
    assign o_out_fluid_body     = r_out_fb;
    assign o_out_fluid_subshape = r_out_fs;
    assign o_out_body_subshape  = r_out_bs;

endmodule

/* rtl/fluid_contact_table_top.sv */
`timescale 1ns / 1ps
// A command passes through the queue, the search state and the commit state,
// which writes the result register. The back end starts a new command only when
// the last has committed; the table has a single write port.
// A 2-entry command queue lets input keep arriving while a result waits.
// Reset (synchronous, active low) empties the table and the queue;
// entry contents are not cleared.
// ----------------------------------------------------------------------------
// fluid_contact_table_top
// Fixed-capacity contact table with add, persist, swap-remove and slot read.
// ----------------------------------------------------------------------------
module fluid_contact_table_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_opcode,
    input  logic [fct_pkg::KEY_W-1:0]   i_fluid_body,
    input  logic [fct_pkg::KEY_W-1:0]   i_fluid_subshape,
    input  logic [fct_pkg::KEY_W-1:0]   i_body_subshape,
    input  logic [fct_pkg::PCNT_W-1:0]  i_point_count,
    input  logic [fct_pkg::SLOT_W-1:0]  i_read_slot,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_status,
    output logic [fct_pkg::SLOT_W-1:0]  o_slot_used,
    output logic [fct_pkg::PIDX_W-1:0]  o_point_index,
    output logic [fct_pkg::CNT_W-1:0]   o_entry_count,
    output logic [fct_pkg::KEY_W-1:0]   o_out_fluid_body,
    output logic [fct_pkg::KEY_W-1:0]   o_out_fluid_subshape,
    output logic [fct_pkg::KEY_W-1:0]   o_out_body_subshape
);
    import fct_pkg::*;

    t_qstat qstat;
    t_cmd   push_cmd;
    t_cmd   head_cmd;
    logic   push;
    logic   pop;

    // accept and classify
    fct_front u_front (
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_opcode         (i_opcode),
        .i_fluid_body     (i_fluid_body),
        .i_fluid_subshape (i_fluid_subshape),
        .i_body_subshape  (i_body_subshape),
        .i_point_count    (i_point_count),
        .i_read_slot      (i_read_slot),
        .i_qstat          (qstat),
        .o_push           (push),
        .o_cmd            (push_cmd)
    );

    // command queue
    fct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_qstat (qstat)
    );

    // table and execution
    fct_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_qstat              (qstat),
        .i_head               (head_cmd),
        .o_pop                (pop),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_status             (o_status),
        .o_slot_used          (o_slot_used),
        .o_point_index        (o_point_index),
        .o_entry_count        (o_entry_count),
        .o_out_fluid_body     (o_out_fluid_body),
        .o_out_fluid_subshape (o_out_fluid_subshape),
        .o_out_body_subshape  (o_out_body_subshape)
    );

endmodule

/* tb/fluid_contact_table_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fluid_contact_table_top_tb
// Self-checking bench for the fluid contact table. A shadow copy of the table
// predicts status, slot, point index, entry count and read keys for every
// accepted transaction. Results are compared in order against that shadow
// while both handshake sides idle at random and the receiver stalls for long
// stretches.
// ----------------------------------------------------------------------------
module fluid_contact_table_top_tb;

    import fct_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int KEY_POOL     = 12;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTS   = 40;

    // expected outcome of one table operation
    typedef struct {
        t_status             status;
        logic [SLOT_W-1:0]   slot;
        logic [PIDX_W-1:0]   pidx;
        logic [CNT_W-1:0]    count;
        logic [KEY_W-1:0]    fb;
        logic [KEY_W-1:0]    fs;
        logic [KEY_W-1:0]    bs;
    } t_contact_result;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                tx_valid = 1'b0;
    logic                o_ready;
    logic [1:0]          tx_opcode = '0;
    logic [KEY_W-1:0]    tx_fluid_body = '0;
    logic [KEY_W-1:0]    tx_fluid_subshape = '0;
    logic [KEY_W-1:0]    tx_body_subshape = '0;
    logic [PCNT_W-1:0]   tx_point_count = '0;
    logic [SLOT_W-1:0]   tx_read_slot = '0;
    logic                o_valid;
    logic                rx_ready = 1'b0;
    logic [1:0]          o_status;
    logic [SLOT_W-1:0]   o_slot_used;
    logic [PIDX_W-1:0]   o_point_index;
    logic [CNT_W-1:0]    o_entry_count;
    logic [KEY_W-1:0]    o_out_fluid_body;
    logic [KEY_W-1:0]    o_out_fluid_subshape;
    logic [KEY_W-1:0]    o_out_body_subshape;

    // shadow table
    logic [KEY_W-1:0]    shadow_fb [CAPACITY];
    logic [KEY_W-1:0]    shadow_fs [CAPACITY];
    logic [KEY_W-1:0]    shadow_bs [CAPACITY];
    logic [PIDX_W-1:0]   shadow_pidx [CAPACITY];
    int unsigned         shadow_count = 0;

    // keys reused across adds so persists and removes find their targets
    logic [KEY_W-1:0]    pool_fb [KEY_POOL];
    logic [KEY_W-1:0]    pool_fs [KEY_POOL];
    logic [KEY_W-1:0]    pool_bs [KEY_POOL];

    t_contact_result     awaited_results [$];
    int                  mismatch_count = 0;
    int                  result_count = 0;
    int                  tx_idle_pct = 0;
    int                  rx_idle_pct = 0;
    int                  rx_hold_req = 0;
    int                  rx_hold_left = 0;
    int                  cycle_count = 0;

    fluid_contact_table_top i_dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_valid              (tx_valid),
        .o_ready              (o_ready),
        .i_opcode             (tx_opcode),
        .i_fluid_body         (tx_fluid_body),
        .i_fluid_subshape     (tx_fluid_subshape),
        .i_body_subshape      (tx_body_subshape),
        .i_point_count        (tx_point_count),
        .i_read_slot          (tx_read_slot),
        .o_valid              (o_valid),
        .i_ready              (rx_ready),
        .o_status             (o_status),
        .o_slot_used          (o_slot_used),
        .o_point_index        (o_point_index),
        .o_entry_count        (o_entry_count),
        .o_out_fluid_body     (o_out_fluid_body),
        .o_out_fluid_subshape (o_out_fluid_subshape),
        .o_out_body_subshape  (o_out_body_subshape)
    );

    // clock
    always #(HALF_PERIOD) clk = ~clk;

    // runaway guard
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // first matching slot below the entry count, -1 if none
    function automatic int find_contact(input logic [KEY_W-1:0] fb,
                                        input logic [KEY_W-1:0] fs,
                                        input logic [KEY_W-1:0] bs);
        for (int i = 0; i < int'(shadow_count); i++) begin
            if (shadow_fb[i] == fb && shadow_fs[i] == fs && shadow_bs[i] == bs)
                return i;
        end
        return -1;
    endfunction

    // apply one accepted transaction to the shadow table and queue its outcome
    task automatic predict_table_op(input t_opcode op,
                                    input logic [KEY_W-1:0] fb,
                                    input logic [KEY_W-1:0] fs,
                                    input logic [KEY_W-1:0] bs,
                                    input logic [PCNT_W-1:0] pc,
                                    input logic [SLOT_W-1:0] rs);
        t_contact_result r;
        int s;
        int unsigned lim;
        int unsigned nxt;
        int unsigned last;
        r.status = ST_OK;
        r.slot   = '0;
        r.pidx   = '0;
        r.fb     = '0;
        r.fs     = '0;
        r.bs     = '0;
        lim = (pc > MAX_POINTS) ? MAX_POINTS : pc;
        case (op)
            OP_ADD: begin
                if (shadow_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_fb[shadow_count]   = fb;
                    shadow_fs[shadow_count]   = fs;
                    shadow_bs[shadow_count]   = bs;
                    shadow_pidx[shadow_count] = '0;
                    r.slot = SLOT_W'(shadow_count);
                    shadow_count++;
                end
            end
            OP_PERSIST: begin
                s = find_contact(fb, fs, bs);
                if (s < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    nxt = shadow_pidx[s] + 1;
                    if (nxt >= lim)
                        nxt = 0;
                    shadow_pidx[s] = PIDX_W'(nxt);
                    r.slot = SLOT_W'(s);
                    r.pidx = shadow_pidx[s];
                end
            end
            OP_REMOVE: begin
                s = find_contact(fb, fs, bs);
                if (s < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    last = shadow_count - 1;
                    r.slot = SLOT_W'(s);
                    r.pidx = shadow_pidx[s];
                    // swap the last entry into the freed slot
                    if (s != int'(last)) begin
                        shadow_fb[s]   = shadow_fb[last];
                        shadow_fs[s]   = shadow_fs[last];
                        shadow_bs[s]   = shadow_bs[last];
                        shadow_pidx[s] = shadow_pidx[last];
                    end
                    shadow_count = last;
                end
            end
            default: begin
                if (rs >= shadow_count) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.slot = rs;
                    r.pidx = shadow_pidx[rs];
                    r.fb   = shadow_fb[rs];
                    r.fs   = shadow_fs[rs];
                    r.bs   = shadow_bs[rs];
                end
            end
        endcase
        r.count = CNT_W'(shadow_count);
        awaited_results = {awaited_results, r};
    endtask

    // offer one transaction, wait for acceptance, then predict it
    task automatic send_contact(input t_opcode op,
                                input logic [KEY_W-1:0] fb,
                                input logic [KEY_W-1:0] fs,
                                input logic [KEY_W-1:0] bs,
                                input logic [PCNT_W-1:0] pc,
                                input logic [SLOT_W-1:0] rs);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            tx_valid <= 1'b0;
            @(negedge clk);
        end
        tx_valid          <= 1'b1;
        tx_opcode         <= op;
        tx_fluid_body     <= fb;
        tx_fluid_subshape <= fs;
        tx_body_subshape  <= bs;
        tx_point_count    <= pc;
        tx_read_slot      <= rs;
        @(posedge clk);
        while (!o_ready)
            @(posedge clk);
        predict_table_op(op, fb, fs, bs, pc, rs);
    endtask

    // one line per mismatch, up to MAX_PRINTS lines
    task automatic report_mismatch(input string field,
                                   input logic [KEY_W-1:0] exp_val,
                                   input logic [KEY_W-1:0] got_val);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("mismatch on %s at result %0d: expected %h, got %h",
                     field, result_count, exp_val, got_val);
    endtask

    // receiver: random ready, with long hold-offs on request
    always @(negedge clk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            rx_ready <= 1'b0;
        end else begin
            rx_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // result checker
    always @(posedge clk) begin : result_check
        t_contact_result exp_r;
        if (rst_n && o_valid && rx_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result", '0, '0);
            end else begin
                exp_r = awaited_results.pop_front();
                if (o_status !== exp_r.status)
                    report_mismatch("status", exp_r.status, o_status);
                if (o_slot_used !== exp_r.slot)
                    report_mismatch("slot_used", exp_r.slot, o_slot_used);
                if (o_point_index !== exp_r.pidx)
                    report_mismatch("point_index", exp_r.pidx, o_point_index);
                if (o_entry_count !== exp_r.count)
                    report_mismatch("entry_count", exp_r.count, o_entry_count);
                if (o_out_fluid_body !== exp_r.fb)
                    report_mismatch("out_fluid_body", exp_r.fb, o_out_fluid_body);
                if (o_out_fluid_subshape !== exp_r.fs)
                    report_mismatch("out_fluid_subshape", exp_r.fs, o_out_fluid_subshape);
                if (o_out_body_subshape !== exp_r.bs)
                    report_mismatch("out_body_subshape", exp_r.bs, o_out_body_subshape);
            end
            result_count++;
        end
    end

    // extremes of every field, each opcode and each corner case
    task automatic test_directed();
        logic [KEY_W-1:0] ka, kb, kc, kd;
        ka = '0;
        kb = '1;
        kc = 32'hAAAA_AAAA;
        kd = 32'h5555_5555;
        // empty table: reads, persist and remove all miss
        send_contact(OP_READ, '0, '0, '0, '0, 3'd0);
        send_contact(OP_READ, '1, '1, '1, '1, 3'd7);
        send_contact(OP_PERSIST, ka, ka, ka, 7'd4, '0);
        send_contact(OP_REMOVE, ka, ka, ka, 7'd4, '0);
        // fill, with a duplicate key
        send_contact(OP_ADD, ka, ka, ka, '1, '1);
        send_contact(OP_ADD, kb, kb, kb, '0, '0);
        send_contact(OP_ADD, kc, kd, kc, 7'd64, 3'd5);
        send_contact(OP_ADD, ka, ka, ka, 7'd1, 3'd2);
        // persist hits the first duplicate; zero count wraps; large count clamps
        send_contact(OP_PERSIST, ka, ka, ka, 7'd3, '0);
        send_contact(OP_PERSIST, ka, ka, ka, 7'd0, '0);
        send_contact(OP_PERSIST, kb, kb, kb, 7'd127, '0);
        send_contact(OP_PERSIST, kb, kb, kb, 7'd65, '0);
        send_contact(OP_ADD, kd, kc, kd, 7'd2, '0);
        send_contact(OP_ADD, 32'd1, 32'd2, 32'd3, '0, '0);
        send_contact(OP_ADD, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, '0, '0);
        send_contact(OP_ADD, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h00FF_FF00, '0, '0);
        // full table
        send_contact(OP_ADD, 32'h1234_5678, kb, ka, '0, '0);
        send_contact(OP_READ, '0, '0, '0, '0, 3'd7);
        // partial key match is a miss
        send_contact(OP_PERSIST, kb, kb, 32'hFFFF_FFFE, 7'd8, '0);
        // swap-remove from the middle, remove the entry swapped in, remove a duplicate
        send_contact(OP_REMOVE, kc, kd, kc, '0, '0);
        send_contact(OP_READ, '0, '0, '0, '0, 3'd2);
        send_contact(OP_REMOVE, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h00FF_FF00, '0, '0);
        send_contact(OP_REMOVE, ka, ka, ka, '0, '0);
        send_contact(OP_READ, '0, '0, '0, '0, 3'd0);
        send_contact(OP_PERSIST, kb, kb, kb, 7'd1, '0);
        send_contact(OP_READ, '0, '0, '0, '0, 3'd6);
    endtask

    // walk one point index all the way up and through its wrap
    task automatic test_point_wrap();
        logic [KEY_W-1:0] kw;
        kw = 32'hC0DE_0001;
        if (shadow_count == CAPACITY)
            send_contact(OP_REMOVE, shadow_fb[0], shadow_fs[0], shadow_bs[0], '0, '0);
        send_contact(OP_ADD, kw, ~kw, kw, '0, '0);
        for (int i = 0; i < 70; i++)
            send_contact(OP_PERSIST, kw, ~kw, kw,
                         PCNT_W'($urandom_range(MAX_POINTS, 127)), '0);
        send_contact(OP_REMOVE, kw, ~kw, kw, '0, '0);
    endtask

    // one random operation, mostly on keys that are present
    task automatic send_random_contact();
        t_opcode op;
        logic [KEY_W-1:0] fb, fs, bs;
        logic [PCNT_W-1:0] pc;
        int roll, k, b;
        roll = $urandom_range(0, 99);
        if (shadow_count == 0 && roll < 60)
            op = OP_ADD;
        else if (shadow_count == CAPACITY && roll < 50)
            op = OP_REMOVE;
        else
            op = t_opcode'($urandom_range(0, 3));
        roll = $urandom_range(0, 99);
        if (shadow_count > 0 && roll < ((op == OP_ADD) ? 20 : 75)) begin
            k  = $urandom_range(0, shadow_count - 1);
            fb = shadow_fb[k];
            fs = shadow_fs[k];
            bs = shadow_bs[k];
            // near miss: one key bit off
            if (op != OP_ADD && $urandom_range(0, 9) == 0) begin
                b = $urandom_range(0, KEY_W - 1);
                case ($urandom_range(0, 2))
                    0: fb[b] = ~fb[b];
                    1: fs[b] = ~fs[b];
                    default: bs[b] = ~bs[b];
                endcase
            end
        end else if (roll < 90) begin
            k  = $urandom_range(0, KEY_POOL - 1);
            fb = pool_fb[k];
            fs = pool_fs[k];
            bs = pool_bs[k];
        end else begin
            fb = $urandom;
            fs = $urandom;
            bs = $urandom;
        end
        roll = $urandom_range(0, 99);
        if (roll < 70)
            pc = PCNT_W'($urandom_range(1, 8));
        else if (roll < 85)
            pc = PCNT_W'($urandom_range(0, 127));
        else
            pc = (roll < 92) ? PCNT_W'(MAX_POINTS) : '0;
        send_contact(op, fb, fs, bs, pc, SLOT_W'($urandom_range(0, CAPACITY - 1)));
    endtask

    task automatic test_random(input int n_items);
        for (int i = 0; i < n_items; i++)
            send_random_contact();
    endtask

    // receiver stalls long enough for the input side to back up
    task automatic test_backpressure();
        rx_hold_req = 80;
        for (int i = 0; i < 12; i++)
            send_random_contact();
    endtask

    initial begin
        for (int i = 0; i < KEY_POOL; i++) begin
            pool_fb[i] = $urandom;
            pool_fs[i] = $urandom;
            pool_bs[i] = $urandom;
        end

        // reset
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 12;
        rx_idle_pct = 81;
        test_directed();
        test_point_wrap();
        test_random(480);
        test_backpressure();

        tx_idle_pct = 81;
        rx_idle_pct = 12;
        test_random(480);
        test_backpressure();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(400);

        @(negedge clk);
        tx_valid <= 1'b0;

        // drain outstanding results
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0)
            report_mismatch("missing results", awaited_results.size(), '0);

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
